// ===== src/nlss_pkg.sv =====
package nlss_pkg;

    localparam int MAX_LINKS = 256;
    localparam int IDX_W = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int CNT_W = $clog2(MAX_LINKS + 1);

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] start_station;
        logic signed [31:0] finish_station;
    } request_t;

    typedef struct packed {
        logic [31:0] distance;
        logic        status;
    } result_t;

    typedef struct packed {
        logic               is_query;
        logic signed [31:0] start_station;
        logic signed [31:0] finish_station;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_head_t;

    // exact |a - b| of two signed stations, fits in 32 unsigned bits
    function automatic logic [31:0] station_dist(logic signed [31:0] a, logic signed [31:0] b);
        logic [32:0] diff;
        logic [32:0] mag;
        diff = {a[31], a} - {b[31], b};
        mag  = diff[32] ? (~diff + 33'd1) : diff;
        return mag[31:0];
    endfunction

endpackage

// ===== src/nlss_front.sv =====
module nlss_front
    import nlss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  request_t  request,
    output logic      busy,
    input  logic      pop,
    output job_head_t head
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    job_t       job_in;

    assign busy = (count_reg == 2'd2);
    assign push = start && !busy;

    always_comb
    begin
        job_in.is_query       = (request.cmd == CMD_QUERY);
        job_in.start_station  = request.start_station;
        job_in.finish_station = request.finish_station;
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

// ===== src/nlss_back.sv =====
module nlss_back
    import nlss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_head_t head,
    output logic      pop,
    output logic      done,
    output result_t   result
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [63:0]        link_mem [MAX_LINKS];
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic signed [31:0] cur_start_reg, cur_start_next;
    logic signed [31:0] cur_finish_reg, cur_finish_next;
    logic [31:0]        best_reg, best_next;

    logic               rd_valid_reg, rd_valid_next;
    logic               rd_last_reg, rd_last_next;
    logic [63:0]        rd_data_reg;

    logic               cmp_valid_reg, cmp_last_reg;
    logic               cmp_ma_reg, cmp_mb_reg;
    logic [31:0]        cmp_da_reg, cmp_db_reg;

    logic               done_reg, done_next;
    result_t            result_reg, result_next;

    logic               wr_en;
    logic               issue_go;
    logic               has_room;
    logic [31:0]        query_dist;
    logic signed [31:0] link_a;
    logic signed [31:0] link_b;
    logic [31:0]        cand;
    logic               cand_valid;
    logic [31:0]        best_new;

    assign has_room   = (fill_reg < CNT_W'(MAX_LINKS));
    assign query_dist = station_dist(head.job.start_station, head.job.finish_station);
    assign issue_go   = (state_reg == ST_SCAN) && (issue_reg < fill_reg);
    assign pop        = (state_reg == ST_IDLE) && head.valid;
    assign wr_en      = pop && !head.job.is_query && has_room;

    assign link_a = rd_data_reg[63:32];
    assign link_b = rd_data_reg[31:0];

    // pick the nearer of the two link ends that match, then fold into the best so far
    always_comb
    begin
        cand_valid = cmp_ma_reg || cmp_mb_reg;
        cand       = (cmp_ma_reg && (!cmp_mb_reg || (cmp_da_reg <= cmp_db_reg)))
                     ? cmp_da_reg : cmp_db_reg;
        best_new   = (cand_valid && (cand < best_reg)) ? cand : best_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        issue_next      = issue_reg;
        cur_start_next  = cur_start_reg;
        cur_finish_next = cur_finish_reg;
        best_next       = best_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        rd_valid_next   = issue_go;
        rd_last_next    = issue_go && ((issue_reg + CNT_W'(1)) == fill_reg);
        if (issue_go)
        begin
            issue_next = issue_reg + CNT_W'(1);
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    if (!head.job.is_query)
                    begin
                        done_next            = 1'b1;
                        result_next.distance = 32'd0;
                        result_next.status   = has_room ? STATUS_DONE : STATUS_FULL;
                        if (has_room)
                        begin
                            fill_next = fill_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        cur_start_next  = head.job.start_station;
                        cur_finish_next = head.job.finish_station;
                        best_next       = query_dist;
                        if (fill_reg == CNT_W'(0))
                        begin
                            done_next            = 1'b1;
                            result_next.distance = query_dist;
                            result_next.status   = STATUS_DONE;
                        end
                        else
                        begin
                            issue_next = CNT_W'(0);
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (cmp_valid_reg)
                begin
                    best_next = best_new;
                    if (cmp_last_reg)
                    begin
                        done_next            = 1'b1;
                        result_next.distance = best_new;
                        result_next.status   = STATUS_DONE;
                        state_next           = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            issue_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
            cmp_last_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            issue_reg     <= issue_next;
            rd_valid_reg  <= rd_valid_next;
            rd_last_reg   <= rd_last_next;
            cmp_valid_reg <= rd_valid_reg;
            cmp_last_reg  <= rd_last_reg;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_start_reg  <= cur_start_next;
        cur_finish_reg <= cur_finish_next;
        best_reg       <= best_next;
        result_reg     <= result_next;
        cmp_ma_reg     <= (link_a == cur_start_reg);
        cmp_mb_reg     <= (link_b == cur_start_reg);
        cmp_da_reg     <= station_dist(cur_finish_reg, link_b);
        cmp_db_reg     <= station_dist(cur_finish_reg, link_a);
    end

    // link store: one write port for adds, one registered read port for the scan
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[fill_reg[IDX_W-1:0]] <= {head.job.start_station, head.job.finish_station};
        end
        rd_data_reg <= link_mem[issue_reg[IDX_W-1:0]];
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== src/nearest_linked_station_search_top.sv =====
// Link table with nearest-station queries. An item is taken when start is high and busy is low;
// up to two items wait in a small queue in front of the table engine, and busy rises only while
// that queue is full. Each item gives exactly one result, shown for one cycle with done high; the
// receiver must take it then. Adds stream at one per cycle while the engine is not scanning a query.
// A query walks every stored link through the single read port of the link memory, one link per
// cycle, so the query rate is set by the number of stored links. For an add taken by an idle
// block, the request is first registered in the queue; the engine then pops it and registers
// its result, which is then shown on the ports.
module nearest_linked_station_search_top
    import nlss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  request_t request,
    output logic     busy,
    output logic     done,
    output result_t  result
);

    job_head_t head;
    logic      pop;

    nlss_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .pop     (pop),
        .head    (head)
    );

    nlss_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule
